// ===== rtl/cdor_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cdor_pkg;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_STEP  = 1'b1;

	localparam int NUM_OCT = 8;

	// octant enable bits in emission order
	localparam logic [7:0] OCT_ORDER [NUM_OCT] = '{
		8'h04, 8'h02, 8'h20, 8'h40, 8'h08, 8'h01, 8'h10, 8'h80
	};

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam logic [QPTR_W:0] QUEUE_FULL = (QPTR_W + 1)'(QUEUE_DEPTH);

	typedef struct packed {
		logic signed [14:0] cx;
		logic signed [14:0] cy;
		logic [13:0]        x;
		logic [14:0]        y;
		logic [NUM_OCT-1:0] ord;
		logic               mode;
		logic               done;
	} job_t;

endpackage

`default_nettype wire

// ===== rtl/cdor_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cdor_front
	import cdor_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,
	input  wire logic        s_tuser,
	input  wire logic        queue_full,
	output logic             push,
	output job_t             push_job
);

	logic signed [14:0] cx_q;
	logic signed [14:0] cy_q;
	logic signed [16:0] err_q;
	logic [13:0]        x_q;
	logic [14:0]        y_q;
	logic [7:0]         mask_q;
	logic               mode_q;
	logic               active_q;

	logic               accept;
	logic               running;
	logic signed [18:0] err_a;
	logic signed [18:0] err_b;
	logic               step_x;
	logic signed [16:0] err_n;
	logic [14:0]        y_n;
	logic [13:0]        x_n;
	logic               done_n;
	logic [NUM_OCT-1:0] ord;

	assign s_tready = !queue_full;
	assign accept   = s_tvalid && s_tready;
	assign push     = accept && (s_tuser == ACT_STEP);
	assign running  = active_q && (y_q <= {1'b0, x_q});

	always_comb begin
		err_a  = 19'(err_q) + 19'(signed'({3'b000, y_q, 1'b1}));
		step_x = err_a > 19'sd0;
		err_b  = err_a - 19'(signed'({4'b0000, x_q, 1'b0})) + 19'sd2;
		err_n  = step_x ? 17'(err_b) : 17'(err_a);
		y_n    = y_q + 15'd1;
		x_n    = step_x ? x_q - 14'd1 : x_q;
		// x stepping below zero only happens for a zero radius
		done_n = (y_n > {1'b0, x_n}) || (step_x && (x_q == '0));
	end

	always_comb begin
		for (int i = 0; i < NUM_OCT; i++) begin
			ord[i] = |(mask_q & OCT_ORDER[i]);
		end
	end

	always_comb begin
		push_job.cx   = cx_q;
		push_job.cy   = cy_q;
		push_job.x    = x_q;
		push_job.y    = y_q;
		push_job.mode = mode_q;
		push_job.ord  = running ? ord : '0;
		push_job.done = running ? done_n : 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			err_q    <= '0;
			x_q      <= '0;
			y_q      <= '0;
			mask_q   <= '0;
			mode_q   <= 1'b0;
			active_q <= 1'b0;
		end else if (accept) begin
			if (s_tuser == ACT_START) begin
				cx_q     <= s_tdata[14:0];
				cy_q     <= s_tdata[29:15];
				x_q      <= s_tdata[43:30];
				y_q      <= '0;
				err_q    <= -17'(signed'({1'b0, s_tdata[43:30]}));
				mask_q   <= s_tdata[51:44];
				mode_q   <= s_tdata[52];
				active_q <= 1'b1;
			end else if (running) begin
				err_q    <= err_n;
				y_q      <= y_n;
				x_q      <= x_n;
				active_q <= !done_n;
			end else begin
				active_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/cdor_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cdor_fifo
	import cdor_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      push_job,
	input  wire logic pop,
	output logic      full,
	output logic      avail,
	output job_t      head
);

	job_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full  = cnt_q == QUEUE_FULL;
	assign avail = cnt_q != '0;
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/cdor_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cdor_back
	import cdor_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_avail,
	input  job_t             q_head,
	output logic             q_pop,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,
	output logic [1:0]       m_tuser,
	output logic             m_tlast
);

	localparam int CB = COORD_BITS;
	localparam int EW = (COORD_BITS > 16) ? COORD_BITS : 16;

	job_t               job_q;
	logic               busy_q;
	logic [NUM_OCT-1:0] rem_q;

	logic               issue;
	logic               last;
	logic               drawn;
	logic [2:0]         idx;
	logic [NUM_OCT-1:0] rem_n;

	logic [CB-1:0] cxw, cyw, xw, yw;
	logic [CB-1:0] px, mx, py, my, qy, ny, qx, nx;
	logic signed [CB-1:0] sx, sy, ex, ey;

	assign issue = busy_q && (!m_tvalid || m_tready);
	assign q_pop = q_avail && (!busy_q || (issue && last));
	assign drawn = rem_q != '0;

	always_comb begin
		idx = '0;
		for (int i = NUM_OCT - 1; i >= 0; i--) begin
			if (rem_q[i]) begin
				idx = 3'(i);
			end
		end
		rem_n = rem_q & ~(NUM_OCT'(1) << idx);
		last  = rem_n == '0;
	end

	always_comb begin
		cxw = CB'(job_q.cx);
		cyw = CB'(job_q.cy);
		xw  = CB'(job_q.x);
		yw  = CB'(job_q.y);
		px  = cxw + xw;
		mx  = cxw - xw;
		py  = cxw + yw;
		my  = cxw - yw;
		qy  = cyw + yw;
		ny  = cyw - yw;
		qx  = cyw + xw;
		nx  = cyw - xw;
		if (!job_q.mode) begin
			case (idx)
				3'd0:    begin sx = px; sy = qy; end
				3'd1:    begin sx = px; sy = ny; end
				3'd2:    begin sx = mx; sy = qy; end
				3'd3:    begin sx = mx; sy = ny; end
				3'd4:    begin sx = py; sy = qx; end
				3'd5:    begin sx = py; sy = nx; end
				3'd6:    begin sx = my; sy = qx; end
				default: begin sx = my; sy = nx; end
			endcase
			ex = sx;
			ey = sy;
		end else begin
			case (idx)
				3'd0: begin
					sx = px;          sy = qy + CB'(1);
					ex = py + CB'(1); ey = sy;
				end
				3'd1: begin
					sx = px;          sy = ny;
					ex = py + CB'(1); ey = sy;
				end
				3'd2: begin
					sx = mx - CB'(1); sy = qy + CB'(1);
					ex = my - CB'(2); ey = sy;
				end
				3'd3: begin
					sx = mx - CB'(1); sy = ny;
					ex = my - CB'(2); ey = sy;
				end
				3'd4: begin
					sx = py;          sy = qx + CB'(1);
					ex = sx;          ey = qy + CB'(1);
				end
				3'd5: begin
					sx = py;          sy = nx;
					ex = sx;          ey = ny;
				end
				3'd6: begin
					sx = my - CB'(1); sy = qx + CB'(1);
					ex = sx;          ey = qy + CB'(1);
				end
				default: begin
					sx = my - CB'(1); sy = nx;
					ex = sx;          ey = ny;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rem_q  <= '0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			rem_q  <= q_head.ord;
		end else if (issue) begin
			busy_q <= !last;
			rem_q  <= rem_n;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (issue) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			m_tlast <= last;
			m_tuser <= {job_q.done, drawn};
			if (drawn) begin
				m_tdata <= {16'(EW'(ey)), 16'(EW'(ex)), 16'(EW'(sy)), 16'(EW'(sx))};
			end else begin
				m_tdata <= '0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/circle_disc_octant_rasterizer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// midpoint circle rasterizer. a start transfer (tuser 0) loads centre, radius,
// octant mask and fill mode and yields nothing; each step transfer (tuser 1)
// yields one result per enabled octant, or a single non-drawing result when
// the mask is empty or the shape is finished. the front end takes one
// transfer per cycle while its four-entry job queue has room; the back end
// emits one result per cycle through its output register while the output is
// not stalled, so a step yields max(1, enabled octants) results, eight with a full mask. coordinates wrap
// at COORD_BITS and are sign-extended or truncated to 16 bits.
module circle_disc_octant_rasterizer
	import cdor_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,  // center_x, center_y, radius, octant_mask, fill_mode
	input  wire logic        s_tuser,  // action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,  // start_x, start_y, end_x, end_y
	output logic [1:0]       m_tuser,  // drawn, shape_done
	output logic             m_tlast   // last_of_step
);

	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_avail;
	job_t push_job;
	job_t head;

	cdor_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.queue_full (q_full),
		.push       (q_push),
		.push_job   (push_job)
	);

	cdor_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.full     (q_full),
		.avail    (q_avail),
		.head     (head)
	);

	cdor_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_avail  (q_avail),
		.q_head   (head),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import cdor_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 330;
	localparam int HOLD_CYCLES    = 300;

	typedef struct {
		logic              action;
		logic signed [14:0] cx;
		logic signed [14:0] cy;
		logic [13:0]       radius;
		logic [7:0]        mask;
		logic              fill;
		bit                wait_idle;
	} cmd_t;

	typedef struct {
		logic        drawn;
		logic [15:0] sx;
		logic [15:0] sy;
		logic [15:0] ex;
		logic [15:0] ey;
		logic        last;
		logic        done;
	} span_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	cmd_t  stim_q[$];
	span_t pending_spans[$];
	cmd_t  offered;
	int    stim_total;

	// predictor copy of the rasterizer state
	int          cen_x, cen_y, err_acc, rx, ry;
	logic [7:0]  oct_mask;
	logic        disc_mode;
	bit          shape_live;

	int items_in, results_out, drawn_out, blank_out, shapes_in, steps_in;
	int errors;
	bit in_xfer;

	int burst_left, gap_left;
	int hold_left, hold_count, mode_left, rx_mode, pat_idx;
	logic [15:0] stall_pat;
	int quiet_cycles;

	circle_disc_octant_rasterizer DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void push_cmd(logic act, logic [14:0] cx, logic [14:0] cy,
			logic [13:0] r, logic [7:0] mask, logic fill, bit wait_idle);
		cmd_t c;
		c.action    = act;
		c.cx        = cx;
		c.cy        = cy;
		c.radius    = r;
		c.mask      = mask;
		c.fill      = fill;
		c.wait_idle = wait_idle;
		stim_q = {stim_q, c};
	endfunction

	function automatic void push_steps(int n);
		for (int i = 0; i < n; i++)
			push_cmd(ACT_STEP, 15'($urandom), 15'($urandom), 14'($urandom), 8'($urandom),
				1'($urandom), 1'b0);
	endfunction

	// starts load state; steps do one midpoint iteration, expected spans in octant order
	function automatic void raster_step(cmd_t c);
		span_t res[$];
		span_t s;
		int x, y, xs, ys, xe, ye;
		bit done;
		if (c.action == ACT_START) begin
			cen_x      = c.cx;
			cen_y      = c.cy;
			rx         = c.radius;
			ry         = 0;
			err_acc    = -rx;
			oct_mask   = c.mask;
			disc_mode  = c.fill;
			shape_live = 1'b1;
			return;
		end
		if (!shape_live || ry > rx) begin
			shape_live = 1'b0;
			s = '{1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b1, 1'b1};
			pending_spans = {pending_spans, s};
			return;
		end
		x = rx;
		y = ry;
		err_acc += 2 * ry + 1;
		ry += 1;
		if (err_acc > 0) begin
			err_acc += -2 * rx + 2;
			rx -= 1;
		end
		done = ry > rx;
		if (done)
			shape_live = 1'b0;
		for (int i = 0; i < NUM_OCT; i++) begin
			if ((oct_mask & OCT_ORDER[i]) == 8'h00)
				continue;
			if (!disc_mode) begin
				case (i)
					0: begin xs = cen_x + x; ys = cen_y + y; end
					1: begin xs = cen_x + x; ys = cen_y - y; end
					2: begin xs = cen_x - x; ys = cen_y + y; end
					3: begin xs = cen_x - x; ys = cen_y - y; end
					4: begin xs = cen_x + y; ys = cen_y + x; end
					5: begin xs = cen_x + y; ys = cen_y - x; end
					6: begin xs = cen_x - y; ys = cen_y + x; end
					default: begin xs = cen_x - y; ys = cen_y - x; end
				endcase
				xe = xs;
				ye = ys;
			end else begin
				case (i)
					0: begin xs = cen_x + x; ys = cen_y + y + 1; xe = cen_x + y + 1; ye = ys; end
					1: begin xs = cen_x + x; ys = cen_y - y; xe = cen_x + y + 1; ye = ys; end
					2: begin xs = cen_x - x - 1; ys = cen_y + y + 1; xe = cen_x - y - 2; ye = ys; end
					3: begin xs = cen_x - x - 1; ys = cen_y - y; xe = cen_x - y - 2; ye = ys; end
					4: begin xs = cen_x + y; ys = cen_y + x + 1; xe = xs; ye = cen_y + y + 1; end
					5: begin xs = cen_x + y; ys = cen_y - x; xe = xs; ye = cen_y - y; end
					6: begin xs = cen_x - y - 1; ys = cen_y + x + 1; xe = xs; ye = cen_y + y + 1; end
					default: begin xs = cen_x - y - 1; ys = cen_y - x; xe = xs; ye = cen_y - y; end
				endcase
			end
			s = '{1'b1, xs[15:0], ys[15:0], xe[15:0], ye[15:0], 1'b0, done};
			res = {res, s};
		end
		if (res.size() == 0) begin
			s = '{1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, done};
			res = {res, s};
		end
		res[res.size() - 1].last = 1'b1;
		pending_spans = {pending_spans, res};
	endfunction

	function automatic void flag_error(string msg);
		errors++;
		if (errors <= 10)
			$display("ERROR at %0t: %s", $realtime, msg);
	endfunction

	// input side: bursts of transfers with random gaps, optional drain before an item
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_xfer)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (stim_q.size() == 0 ||
					(stim_q[0].wait_idle && pending_spans.size() != 0)) begin
				s_tvalid <= 1'b0;
			end else begin
				cmd_t c;
				c = stim_q.pop_front();
				offered  <= c;
				s_tvalid <= 1'b1;
				s_tuser  <= c.action;
				s_tdata  <= {3'b000, c.fill, c.mask, c.radius, c.cy, c.cx};
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end
		end
	end

	// output side: no stalls, a fixed stall pattern or random stalls, plus long hold-offs
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_count < 2 && items_in >= 60 + 150 * hold_count) begin
				hold_left = HOLD_CYCLES;
				hold_count++;
			end
			if (mode_left == 0) begin
				rx_mode   = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 150);
				stall_pat = 16'($urandom) | 16'h0101;
			end else begin
				mode_left--;
			end
			pat_idx++;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (rx_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= stall_pat[pat_idx % 16];
					default: m_tready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// check results, then predict for the item taken in the same cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				span_t got, exp_s;
				got = '{m_tuser[0], m_tdata[15:0], m_tdata[31:16], m_tdata[47:32],
					m_tdata[63:48], m_tlast, m_tuser[1]};
				results_out++;
				if (got.drawn)
					drawn_out++;
				else
					blank_out++;
				if (pending_spans.size() == 0) begin
					flag_error($sformatf("unexpected result d%0b %h %h %h %h l%0b f%0b",
						got.drawn, got.sx, got.sy, got.ex, got.ey, got.last, got.done));
				end else begin
					exp_s = pending_spans.pop_front();
					if (got.drawn !== exp_s.drawn || got.sx !== exp_s.sx ||
							got.sy !== exp_s.sy || got.ex !== exp_s.ex ||
							got.ey !== exp_s.ey || got.last !== exp_s.last ||
							got.done !== exp_s.done)
						flag_error($sformatf(
							"exp d%0b %h %h %h %h l%0b f%0b got d%0b %h %h %h %h l%0b f%0b",
							exp_s.drawn, exp_s.sx, exp_s.sy, exp_s.ex, exp_s.ey,
							exp_s.last, exp_s.done, got.drawn, got.sx, got.sy,
							got.ex, got.ey, got.last, got.done));
				end
			end
			if (s_tvalid && s_tready) begin
				raster_step(offered);
				items_in++;
				if (offered.action == ACT_START)
					shapes_in++;
				else
					steps_in++;
			end
			in_xfer <= s_tvalid && s_tready;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("circle_disc_octant_rasterizer test failed");
				$finish;
			end
		end
	end

	initial begin
		int kind, r, nsteps, xx, yy, ee, sel, seq;
		bit big;
		logic [7:0] mask;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = ACT_START;
		m_tready = 1'b0;
		in_xfer  = 1'b0;
		shape_live = 1'b0;
		cen_x = 0; cen_y = 0; err_acc = 0; rx = 0; ry = 0;
		oct_mask = 8'h00; disc_mode = 1'b0;
		items_in = 0; results_out = 0; drawn_out = 0; blank_out = 0;
		shapes_in = 0; steps_in = 0; errors = 0; quiet_cycles = 0;
		burst_left = 0; gap_left = 0; hold_left = 0; hold_count = 0;
		mode_left = 0; rx_mode = 0; pat_idx = 0; stall_pat = 16'hffff;

		// directed: step with nothing running, zero radius, extremes, empty mask
		push_steps(1);
		push_cmd(ACT_START, 15'sd0, 15'sd0, 14'd0, 8'hff, 1'b0, 1'b0);
		push_steps(2);
		push_cmd(ACT_START, 15'h3fff, 15'h4000, 14'h3fff, 8'hff, 1'b1, 1'b0);
		push_steps(2);
		push_cmd(ACT_START, 15'h4000, 15'h3fff, 14'h3fff, 8'hff, 1'b0, 1'b0);
		push_steps(1);
		push_cmd(ACT_START, 15'd5, -15'sd7, 14'd3, 8'h00, 1'b0, 1'b0);
		push_steps(3);
		push_cmd(ACT_START, -15'sd100, 15'sd50, 14'd5, 8'ha5, 1'b1, 1'b0);
		push_steps(5);
		push_cmd(ACT_START, 15'sd1, 15'sd2, 14'd1, 8'h5a, 1'b0, 1'b0);
		push_steps(2);
		push_cmd(ACT_START, -15'sd3, 15'sd9, 14'd9, 8'hff, 1'b0, 1'b1);
		push_steps(1);
		push_cmd(ACT_START, 15'sd20, -15'sd20, 14'd2, 8'hff, 1'b1, 1'b0);
		push_steps(3);

		// random shapes: mostly complete circles, some cut short, some stray steps
		seq = 0;
		while (stim_q.size() < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			if (kind == 9) begin
				push_steps($urandom_range(1, 3));
			end else begin
				big = ($urandom_range(0, 4) == 0);
				r   = big ? $urandom_range(0, 16383) : $urandom_range(0, 24);
				sel = $urandom_range(0, 7);
				mask = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hff : 8'($urandom);
				push_cmd(ACT_START, 15'($urandom), 15'($urandom), 14'(r), mask,
					1'($urandom), (seq % 16) == 0);
				if (big) begin
					nsteps = $urandom_range(1, 6);
				end else begin
					xx = r; yy = 0; ee = -r; nsteps = 0;
					while (yy <= xx) begin
						ee += 2 * yy + 1;
						yy++;
						if (ee > 0) begin
							ee += -2 * xx + 2;
							xx--;
						end
						nsteps++;
					end
				end
				if (kind >= 7)
					nsteps = $urandom_range(0, nsteps);
				else if (!big)
					nsteps += $urandom_range(0, 1);
				push_steps(nsteps);
			end
			seq++;
		end
		stim_total = stim_q.size();

		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		wait (items_in == stim_total);
		while (pending_spans.size() != 0)
			@(posedge clk);
		repeat (32) @(posedge clk);

		$display("%0d transfers in: %0d shape loads, %0d steps", items_in, shapes_in, steps_in);
		$display("%0d results out: %0d drawn, %0d blank; %0d mismatches",
			results_out, drawn_out, blank_out, errors);
		if (errors == 0)
			$display("circle_disc_octant_rasterizer test passed");
		else
			$display("circle_disc_octant_rasterizer test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/cdor_pkg.sv
rtl/cdor_front.sv
rtl/cdor_fifo.sv
rtl/cdor_back.sv
rtl/circle_disc_octant_rasterizer.sv
test/testbench.sv
